// ----- sv/oam_line_sprite_select_defines.svh -----
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef OAM_LINE_SPRITE_SELECT_DEFINES_SVH
`define OAM_LINE_SPRITE_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OAMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oams check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OAMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oams check failed");

`endif

// ----- sv/oams_pkg.sv -----
package oams_pkg;

  localparam int MAX_PER_LINE_DEF = 10;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attr;
  } sprite_t;

  typedef struct packed {
    logic       first_entry;
    logic       last_entry;
    logic [7:0] line;
    logic [7:0] sprite_y;
    logic [7:0] sprite_x;
    logic [7:0] tile;
    logic [7:0] attributes;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_y;
    logic [7:0] out_x;
    logic [7:0] out_tile;
    logic [7:0] out_attributes;
    logic       none_found;
    logic       last_of_run;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic    insert;
    logic    rotate;
    logic    clear;
    sprite_t item;
  } cell_ctrl_t;

endpackage

// ----- sv/oams_cell.sv -----
module oams_cell
  import oams_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       left_valid,
  input  logic       left_gt,
  input  sprite_t    left_data,
  input  logic       right_valid,
  input  sprite_t    right_data,
  input  sprite_t    head_data,
  output logic       valid_eff,
  output logic       gt,
  output sprite_t    data
);

  logic valid;
  logic ins;

  // A clear from a new scan takes effect in the same cycle as its own entry.
  always_comb begin
    valid_eff = valid & ~ctrl.clear;
    gt        = valid_eff && (data.x > ctrl.item.x);
    ins       = (!valid_eff || gt) && left_valid && !left_gt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && (left_gt || ins)) begin
      valid <= 1'b1;
    end else begin
      valid <= valid_eff;
    end
  end

  // Insert shifts larger entries one place right; rotate moves the list one
  // place left and wraps the head onto the tail.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        data <= left_data;
      end else if (ins) begin
        data <= ctrl.item;
      end
    end else if (ctrl.rotate) begin
      if (right_valid) begin
        data <= right_data;
      end else if (valid) begin
        data <= head_data;
      end
    end
  end

endmodule

// ----- sv/oam_line_sprite_select.sv -----
// Line sprite selection: scans object-attribute entries for one display line
// and returns the sprites that cover it, sorted by ascending x.
// Input channel: an entry (item) is taken at a rising edge where start is high
// and busy is low. Entries carry first_entry to open a new scan and last_entry
// to close it. Ordinary entries are taken one per cycle while busy is low.
// Output channel: result_valid marks each result for exactly one cycle; the
// receiver cannot hold results off, so the output has no stall path.
// Readout: after a transaction with last_entry set, busy rises the next cycle
// and stays high until every held sprite is emitted, or for the empty marker.
// The first result shows in the cycle after busy rises, then one per cycle;
// when nothing was selected a single result with none_found set is given.
// No entry is taken while busy is high; readout is paced by the rotation of
// the cell chain, which moves one place per cycle.
// Storage is a chain of MAX_PER_LINE cells. On insertion every cell whose x
// exceeds the new x hands its sprite to its right neighbor, keeping scan order
// for equal x. Readout rotates the chain so the list survives for re-emission.
// Reset clears the cell valid bits, the emit state and tall_sprites; no
// clearing pass is needed. cfg_write loads tall_sprites (16-line sprites).
module oam_line_sprite_select
  import oams_pkg::*;
#(
  parameter int MAX_PER_LINE = MAX_PER_LINE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      result_valid,
  output out_item_t result,
  input  logic      cfg_write,
  input  logic      cfg_data
);

  localparam int CNT_W = $clog2(MAX_PER_LINE + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state, state_next;
  logic tall_sprites;
  logic [CNT_W-1:0] emit_idx, emit_idx_next;

  logic accept;
  logic [8:0] target;
  logic [8:0] bottom;
  logic hit;
  cell_ctrl_t ctrl;

  sprite_t cell_data [MAX_PER_LINE];
  logic [MAX_PER_LINE-1:0] cell_veff;
  logic [MAX_PER_LINE-1:0] cell_gt;
  logic [MAX_PER_LINE:0] valid_ext;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_write) begin
      tall_sprites <= cfg_data;
    end
  end

  assign busy   = (state == S_EMIT);
  assign accept = start && !busy;

  // Window test at 9 bits so line+16 and y+height never wrap.
  always_comb begin
    target = {1'b0, item.line} + 9'd16;
    bottom = {1'b0, item.sprite_y} + (tall_sprites ? 9'd16 : 9'd8);
    hit    = (item.sprite_x != 8'd0) && ({1'b0, item.sprite_y} <= target) &&
             (bottom > target);
  end

  // The list is full when the last cell holds a sprite after any clear.
  always_comb begin
    ctrl.clear     = accept && item.first_entry;
    ctrl.insert    = accept && hit && !cell_veff[MAX_PER_LINE-1];
    ctrl.rotate    = busy && cell_veff[0];
    ctrl.item.y    = item.sprite_y;
    ctrl.item.x    = item.sprite_x;
    ctrl.item.tile = item.tile;
    ctrl.item.attr = item.attributes;
  end

  for (genvar i = 0; i < MAX_PER_LINE; i++) begin : g_cell
    logic    l_valid;
    logic    l_gt;
    sprite_t l_data;
    logic    r_valid;
    sprite_t r_data;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_data  = ctrl.item;
    end else begin : g_body
      assign l_valid = cell_veff[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_data  = cell_data[i-1];
    end

    if (i == MAX_PER_LINE - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_data  = cell_data[i];
    end else begin : g_mid
      assign r_valid = cell_veff[i+1];
      assign r_data  = cell_data[i+1];
    end

    oams_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .left_data  (l_data),
      .right_valid(r_valid),
      .right_data (r_data),
      .head_data  (cell_data[0]),
      .valid_eff  (cell_veff[i]),
      .gt         (cell_gt[i]),
      .data       (cell_data[i])
    );
  end

  assign valid_ext     = {1'b0, cell_veff};
  assign emit_idx_next = emit_idx + CNT_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.last_entry) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!cell_veff[0] || !valid_ext[emit_idx_next]) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      emit_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      emit_idx     <= busy ? emit_idx_next : '0;
      result_valid <= busy;
    end
  end

  // Result register: the head cell during readout, or the empty marker.
  always_ff @(posedge clk) begin
    if (busy) begin
      if (cell_veff[0]) begin
        result.out_y          <= cell_data[0].y;
        result.out_x          <= cell_data[0].x;
        result.out_tile       <= cell_data[0].tile;
        result.out_attributes <= cell_data[0].attr;
        result.none_found     <= 1'b0;
        result.last_of_run    <= !valid_ext[emit_idx_next];
      end else begin
        result.out_y          <= 8'd0;
        result.out_x          <= 8'd0;
        result.out_tile       <= 8'd0;
        result.out_attributes <= 8'd0;
        result.none_found     <= 1'b1;
        result.last_of_run    <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/oams_checker.sv -----
`include "oam_line_sprite_select_defines.svh"

module oams_checker
  import oams_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  item,
  input logic      result_valid,
  input out_item_t result
);

  // A closing transaction always starts a readout.
  `OAMS_ASSERT_NEXT(a_last_starts_emit, start && !busy && item.last_entry, busy)

  // Results only follow a closing transaction or an ongoing readout.
  `OAMS_ASSERT_NEXT(a_no_stray_result, start && !busy && !item.last_entry, !result_valid)

  // The empty marker is a run of its own, with zeroed sprite fields.
  `OAMS_ASSERT_NOW(a_empty_alone, result_valid && result.none_found, result.last_of_run && result.out_x == 8'd0 && result.out_y == 8'd0)

  // A held sprite never has x of zero.
  `OAMS_ASSERT_NOW(a_sprite_visible, result_valid && !result.none_found, result.out_x != 8'd0)

endmodule

bind oam_line_sprite_select oams_checker u_oams_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .item        (item),
  .result_valid(result_valid),
  .result      (result)
);
